@@ rtl/extended_multiply_divide_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Extended multiply / divide unit: assertion macros
// Concurrent assertion helpers used by the top-level RTL file of the unit.
// ----------------------------------------------------------------------------
`ifndef EXTENDED_MULTIPLY_DIVIDE_UNIT_MACROS_SVH
`define EXTENDED_MULTIPLY_DIVIDE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define EMDU_ASSERT_SAME(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define EMDU_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define EMDU_ASSERT_SAME(label, clk, rstn, a, b)
`define EMDU_ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

@@ rtl/emdu_pkg.sv @@
// ----------------------------------------------------------------------------
// Extended multiply / divide unit package
// Types and constants shared by the pipeline stages and the top level.
// ----------------------------------------------------------------------------
package emdu_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned DIV_STAGES  = 8;
    localparam int unsigned DIV_STEPS   = 8;   // restoring steps per stage

    typedef enum logic {
        CMD_EDIV = 1'b0,
        CMD_EMUL = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_ALIGN    = 2'd1,
        FAULT_DIV_ZERO = 2'd2
    } fault_t;

    // Work carried down the pipeline alongside its valid bit.
    typedef struct packed {
        fault_t                  fault;
        logic                    is_mul;
        logic [WORD_W-1:0]       divisor;
        logic [WORD_W-1:0]       rem;
        logic [2*WORD_W-1:0]     num;     // numerator in, quotient out
        logic [2*WORD_W-1:0]     prod;
    } stage_t;

endpackage

@@ rtl/extended_multiply_divide_unit.sv @@
// ----------------------------------------------------------------------------
// Extended multiply / divide unit
// Pipelined 32x32 unsigned multiply and 64-by-32 unsigned divide with
// operand alignment and divide-by-zero fault detection.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_        in         cmd, src1_value, src2_low, src2_high, src2_is_literal,
//                       src2_index, dest_index
//  m_        out        dest_word, next_word, fault_code
//
// One request enters per cycle while m_ready does not stall the pipeline.
// Each result passes through the front stage and then every divider stage
// register in order before it is presented on m_valid. There are nine
// register stages: the front stage plus eight divider stages of eight
// restoring steps each, and both operations pass through all of them.
// Reset (aresetn, synchronous, active low) empties every stage.
// A stall on m_ready holds only the stages that are full; bubbles further
// up still close, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "extended_multiply_divide_unit_macros.svh"

module extended_multiply_divide_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [31:0] s_src1_value,
    input  logic [31:0] s_src2_low,
    input  logic [31:0] s_src2_high,
    input  logic        s_src2_is_literal,
    input  logic [4:0]  s_src2_index,
    input  logic [4:0]  s_dest_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_dest_word,
    output logic [31:0] m_next_word,
    output logic [1:0]  m_fault_code
);
    import emdu_pkg::*;

    // Stage 0 is the front stage; stages 1 to DIV_STAGES are divider stages.
    logic   stg_valid [DIV_STAGES+1];
    logic   stg_ready [DIV_STAGES+1];
    stage_t stg_data  [DIV_STAGES+1];
    stage_t last;

    emdu_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .cmd             (s_cmd),
        .src1_value      (s_src1_value),
        .src2_low        (s_src2_low),
        .src2_high       (s_src2_high),
        .src2_is_literal (s_src2_is_literal),
        .src2_index      (s_src2_index),
        .dest_index      (s_dest_index),
        .out_valid       (stg_valid[0]),
        .out_ready       (stg_ready[0]),
        .out_data        (stg_data[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        emdu_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_data   (stg_data[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_data  (stg_data[g+1])
        );
    end

    assign stg_ready[DIV_STAGES] = m_ready;
    assign last                  = stg_data[DIV_STAGES];
    assign m_valid               = stg_valid[DIV_STAGES];

    // A fault forces both words to all ones; otherwise pick the product or
    // the remainder and low quotient word.
    always_comb begin
        m_fault_code = last.fault;
        if (last.fault != FAULT_NONE) begin
            m_dest_word = '1;
            m_next_word = '1;
        end else if (last.is_mul) begin
            m_dest_word = last.prod[WORD_W-1:0];
            m_next_word = last.prod[2*WORD_W-1:WORD_W];
        end else begin
            m_dest_word = last.rem;
            m_next_word = last.num[WORD_W-1:0];
        end
    end

    `EMDU_ASSERT_SAME(a_fault_ones, aclk, aresetn, m_valid && (m_fault_code != FAULT_NONE), (m_dest_word == '1) && (m_next_word == '1))
    `EMDU_ASSERT_SAME(a_fault_legal, aclk, aresetn, m_valid, m_fault_code <= FAULT_DIV_ZERO)
    `EMDU_ASSERT_NEXT(a_front_fill, aclk, aresetn, s_valid && s_ready, stg_valid[0])

endmodule

@@ rtl/emdu_front.sv @@
// ----------------------------------------------------------------------------
// Front stage
// Decodes faults, prepares the numerator and forms the 64-bit product.
// ----------------------------------------------------------------------------
module emdu_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       cmd,
    input  logic [31:0]                src1_value,
    input  logic [31:0]                src2_low,
    input  logic [31:0]                src2_high,
    input  logic                       src2_is_literal,
    input  logic [4:0]                 src2_index,
    input  logic [4:0]                 dest_index,
    output logic                       out_valid,
    input  logic                       out_ready,
    output emdu_pkg::stage_t           out_data
);
    import emdu_pkg::*;

    logic   valid_reg, valid_next;
    stage_t data_reg, data_next;
    logic   is_div;

    assign in_ready = !valid_reg || out_ready;
    assign is_div   = (cmd_t'(cmd) == CMD_EDIV);

    always_comb begin
        data_next.is_mul  = !is_div;
        data_next.divisor = src1_value;
        data_next.rem     = '0;
        data_next.num     = src2_is_literal ? {32'd0, src2_low} : {src2_high, src2_low};
        data_next.prod    = {32'd0, src1_value} * {32'd0, src2_low};
        if (dest_index[0] || (is_div && !src2_is_literal && src2_index[0])) begin
            data_next.fault = FAULT_ALIGN;
        end else if (is_div && (src1_value == '0)) begin
            data_next.fault = FAULT_DIV_ZERO;
        end else begin
            data_next.fault = FAULT_NONE;
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/emdu_div_stage.sv @@
// ----------------------------------------------------------------------------
// Divider stage
// Eight restoring division steps followed by a pipeline register.
// ----------------------------------------------------------------------------
module emdu_div_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  emdu_pkg::stage_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output emdu_pkg::stage_t  out_data
);
    import emdu_pkg::*;

    logic   valid_reg, valid_next;
    stage_t data_reg, data_next;

    assign in_ready = !valid_reg || out_ready;

    // Each step shifts one numerator bit into the partial remainder.
    always_comb begin
        logic [WORD_W:0]     trial;
        logic [WORD_W:0]     diff;
        logic [WORD_W-1:0]   rem;
        logic [2*WORD_W-1:0] num;
        rem = in_data.rem;
        num = in_data.num;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial = {rem, num[2*WORD_W-1]};
            diff  = trial - {1'b0, in_data.divisor};
            if (trial >= {1'b0, in_data.divisor}) begin
                rem = diff[WORD_W-1:0];
                num = {num[2*WORD_W-2:0], 1'b1};
            end else begin
                rem = trial[WORD_W-1:0];
                num = {num[2*WORD_W-2:0], 1'b0};
            end
        end
        data_next     = in_data;
        data_next.rem = rem;
        data_next.num = num;
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ tb/sv/extended_multiply_divide_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Extended multiply / divide unit testbench
// Drives extended divide and multiply requests with random idling on both
// channels except in the final phase, predicts every result in the bench
// and checks each result field by field, in order, against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module extended_multiply_divide_unit_tb;
    import emdu_pkg::*;

    // The handshake that moves one result carries these three fields.
    typedef struct {
        logic [31:0] dest_word;
        logic [31:0] next_word;
        fault_t      fault;
    } emdu_result_t;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_cmd;
    logic [31:0] s_src1_value;
    logic [31:0] s_src2_low;
    logic [31:0] s_src2_high;
    logic        s_src2_is_literal;
    logic [4:0]  s_src2_index;
    logic [4:0]  s_dest_index;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_dest_word;
    logic [31:0] m_next_word;
    logic [1:0]  m_fault_code;

    emdu_result_t expected_results[$];
    int unsigned  error_count;
    int unsigned  cycle_count;
    bit           idling_enabled;

    extended_multiply_divide_unit u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_src1_value      (s_src1_value),
        .s_src2_low        (s_src2_low),
        .s_src2_high       (s_src2_high),
        .s_src2_is_literal (s_src2_is_literal),
        .s_src2_index      (s_src2_index),
        .s_dest_index      (s_dest_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_dest_word       (m_dest_word),
        .m_next_word       (m_next_word),
        .m_fault_code      (m_fault_code)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Works out what the unit should return for one request. Alignment is
    // checked before the divisor, so an odd register beats a zero divisor.
    function automatic emdu_result_t predict_extended_op(
        cmd_t cmd, logic [31:0] src1, logic [31:0] src2_lo, logic [31:0] src2_hi,
        logic is_literal, logic [4:0] src2_idx, logic [4:0] dest_idx);
        emdu_result_t res;
        logic [63:0]  numerator;
        logic [63:0]  product;
        res.dest_word = ALL_ONES;
        res.next_word = ALL_ONES;
        res.fault     = FAULT_NONE;
        if (dest_idx[0] || (cmd == CMD_EDIV && !is_literal && src2_idx[0])) begin
            res.fault = FAULT_ALIGN;
        end else if (cmd == CMD_EMUL) begin
            product       = {32'd0, src1} * {32'd0, src2_lo};
            res.dest_word = product[31:0];
            res.next_word = product[63:32];
        end else if (src1 == 32'd0) begin
            res.fault = FAULT_DIV_ZERO;
        end else begin
            numerator     = is_literal ? {32'd0, src2_lo} : {src2_hi, src2_lo};
            res.dest_word = 32'(numerator % {32'd0, src1});
            res.next_word = 32'(numerator / {32'd0, src1});
        end
        return res;
    endfunction

    // Presents one request, optionally after a random idle burst, and holds
    // it until the unit takes it. The expectation is queued at acceptance.
    task automatic send_request(cmd_t cmd, logic [31:0] src1, logic [31:0] src2_lo,
                                logic [31:0] src2_hi, logic is_literal,
                                logic [4:0] src2_idx, logic [4:0] dest_idx);
        int unsigned gap;
        if (idling_enabled && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_cmd             <= cmd;
        s_src1_value      <= src1;
        s_src2_low        <= src2_lo;
        s_src2_high       <= src2_hi;
        s_src2_is_literal <= is_literal;
        s_src2_index      <= src2_idx;
        s_dest_index      <= dest_idx;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_extended_op(cmd, src1, src2_lo, src2_hi,
                                                       is_literal, src2_idx, dest_idx));
    endtask

    // Lowers valid once the last request of a phase has been taken.
    task automatic release_channel();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // The sender holds off until every outstanding result has come back.
    task automatic wait_for_empty_pipeline();
        release_channel();
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Boundary operands, every operation and each fault path.
    task automatic test_directed();
        send_request(CMD_EMUL, 32'd0, 32'd0, 32'd0, 1'b0, 5'd0, 5'd0);
        send_request(CMD_EMUL, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 5'd31, 5'd30);
        send_request(CMD_EMUL, ALL_ONES, 32'd1, 32'd0, 1'b0, 5'd1, 5'd2);
        send_request(CMD_EMUL, 32'h8000_0000, 32'h8000_0000, 32'd0, 1'b0, 5'd3, 5'd4);
        send_request(CMD_EMUL, 32'd5, 32'd7, 32'd0, 1'b0, 5'd0, 5'd31);
        send_request(CMD_EDIV, 32'd7, 32'd100, 32'd0, 1'b1, 5'd0, 5'd0);
        send_request(CMD_EDIV, 32'd7, 32'd100, ALL_ONES, 1'b1, 5'd31, 5'd2);
        send_request(CMD_EDIV, 32'd3, 32'd10, 32'd1, 1'b0, 5'd4, 5'd6);
        send_request(CMD_EDIV, 32'd1, ALL_ONES, ALL_ONES, 1'b0, 5'd30, 5'd28);
        send_request(CMD_EDIV, ALL_ONES, ALL_ONES, 32'hFFFF_FFFE, 1'b0, 5'd0, 5'd0);
        send_request(CMD_EDIV, ALL_ONES, 32'd0, ALL_ONES, 1'b0, 5'd2, 5'd0);
        send_request(CMD_EDIV, 32'd2, 32'd1, 32'h8000_0000, 1'b0, 5'd8, 5'd10);
        send_request(CMD_EDIV, 32'd0, 32'd5, 32'd5, 1'b0, 5'd0, 5'd0);
        send_request(CMD_EDIV, 32'd0, 32'd5, 32'd0, 1'b1, 5'd1, 5'd0);
        send_request(CMD_EDIV, 32'd9, 32'd5, 32'd5, 1'b0, 5'd0, 5'd1);
        send_request(CMD_EDIV, 32'd9, 32'd5, 32'd5, 1'b0, 5'd3, 5'd0);
        send_request(CMD_EDIV, 32'd0, 32'd5, 32'd5, 1'b0, 5'd3, 5'd0);
        send_request(CMD_EDIV, 32'd0, 32'd5, 32'd5, 1'b1, 5'd0, 5'd31);
        send_request(CMD_EDIV, 32'd9, 32'd5, 32'd5, 1'b1, 5'd31, 5'd0);
        send_request(CMD_EDIV, ALL_ONES, 32'd0, 32'd0, 1'b0, 5'd0, 5'd0);
    endtask

    // Random requests; operand widths are skewed so that small divisors,
    // large quotients and zero values turn up often.
    task automatic test_random(int unsigned count);
        logic [31:0] src1;
        logic [31:0] src2_lo;
        logic [31:0] src2_hi;
        cmd_t        cmd;
        for (int unsigned i = 0; i < count; i++) begin
            cmd     = $urandom_range(0, 1) ? CMD_EMUL : CMD_EDIV;
            src1    = $urandom();
            src2_lo = $urandom();
            src2_hi = $urandom();
            case ($urandom_range(0, 5))
                0: src1 = $urandom_range(0, 3);
                1: src1 = $urandom() >> $urandom_range(0, 31);
                2: src2_hi = src2_hi >> $urandom_range(0, 31);
                default: ;
            endcase
            // Mostly aligned operands, so that the arithmetic paths dominate.
            send_request(cmd, src1, src2_lo, src2_hi, 1'($urandom_range(0, 1)),
                         5'($urandom_range(0, 7) == 0 ? $urandom() : $urandom() & 30),
                         5'($urandom_range(0, 7) == 0 ? $urandom() : $urandom() & 30));
        end
    endtask

    // Result side: random stalls on m_ready while idling is enabled.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (idling_enabled && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Checks each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        emdu_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result dest %h next %h fault %0d",
                         $time, m_dest_word, m_next_word, m_fault_code);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (m_dest_word !== exp_res.dest_word) begin
                    $display("%0t: dest_word expected %h actual %h",
                             $time, exp_res.dest_word, m_dest_word);
                    error_count++;
                end
                if (m_next_word !== exp_res.next_word) begin
                    $display("%0t: next_word expected %h actual %h",
                             $time, exp_res.next_word, m_next_word);
                    error_count++;
                end
                if (m_fault_code !== exp_res.fault) begin
                    $display("%0t: fault_code expected %0d actual %0d",
                             $time, exp_res.fault, m_fault_code);
                    error_count++;
                end
            end
        end
    end

    // A watchdog that ends a hung run.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        error_count       = 0;
        idling_enabled    = 1'b1;
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_cmd             <= 1'b0;
        s_src1_value      <= 32'd0;
        s_src2_low        <= 32'd0;
        s_src2_high       <= 32'd0;
        s_src2_is_literal <= 1'b0;
        s_src2_index      <= 5'd0;
        s_dest_index      <= 5'd0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        // The pipeline drains completely before the random phase starts.
        wait_for_empty_pipeline();
        test_random(1200);
        // The final stretch runs back to back with no idling at all.
        idling_enabled = 1'b0;
        test_random(300);
        release_channel();

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
